FILE: rtl/aau_pkg.sv
// Shared types and codes for the accumulator ALU with pair operations.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package aau_pkg;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_ADC = 4'd1,
    OP_SUB = 4'd2,
    OP_SBB = 4'd3,
    OP_INR = 4'd4,
    OP_DCR = 4'd5,
    OP_ADI = 4'd6,
    OP_ACI = 4'd7,
    OP_SUI = 4'd8,
    OP_SBI = 4'd9,
    OP_INX = 4'd10,
    OP_DCX = 4'd11,
    OP_DAD = 4'd12
  } op_t;

  // byte operand selectors that are not general registers
  localparam logic [2:0] SEL_M = 3'd6;
  localparam logic [2:0] SEL_A = 3'd7;

  // pair selector for the stack pointer and for HL
  localparam logic [1:0] PAIR_HL = 2'd2;
  localparam logic [1:0] PAIR_SP = 2'd3;

  localparam int unsigned NUM_GREGS = 6;

  typedef struct packed {
    logic s;
    logic z;
    logic ac;
    logic p;
    logic cy;
  } flags_t;

  typedef struct packed {
    logic [7:0]                acc;
    logic [NUM_GREGS-1:0][7:0] gregs;  // B, C, D, E, H, L
    logic [15:0]               sp;
    flags_t                    flags;
  } state_t;

  typedef struct packed {
    logic [3:0] opcode;
    logic [2:0] reg_select;
    logic [7:0] imm_value;
    logic [7:0] mem_data;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  acc_out;
    flags_t      flags;
    logic        mem_write;
    logic [7:0]  mem_wdata;
    logic [15:0] hl_address;
    logic [15:0] pair_result;
  } res_t;

endpackage

FILE: rtl/aau_if.sv
// Valid/ready channel interfaces for the instruction and result words.
// No dependencies.
`timescale 1ns / 1ps

interface aau_cmd_if;
  logic       valid;
  logic       ready;
  logic [3:0] opcode;
  logic [2:0] reg_select;
  logic [7:0] imm_value;
  logic [7:0] mem_data;

  modport source (output valid, output opcode, output reg_select, output imm_value,
                  output mem_data, input ready);
  modport sink (input valid, input opcode, input reg_select, input imm_value,
                input mem_data, output ready);
endinterface

interface aau_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  acc_out;
  logic        sign_flag;
  logic        zero_flag;
  logic        aux_carry_flag;
  logic        parity_flag;
  logic        carry_flag_out;
  logic        mem_write;
  logic [7:0]  mem_wdata;
  logic [15:0] hl_address;
  logic [15:0] pair_result;

  modport source (output valid, output acc_out, output sign_flag, output zero_flag,
                  output aux_carry_flag, output parity_flag, output carry_flag_out,
                  output mem_write, output mem_wdata, output hl_address,
                  output pair_result, input ready);
  modport sink (input valid, input acc_out, input sign_flag, input zero_flag,
                input aux_carry_flag, input parity_flag, input carry_flag_out,
                input mem_write, input mem_wdata, input hl_address,
                input pair_result, output ready);
endinterface

FILE: rtl/aau_regs.sv
// Architectural register state: A, B-L, SP and flags.
// Depends on aau_pkg.
`timescale 1ns / 1ps

module aau_regs (
  input  logic            clk,
  input  logic            rst,
  input  logic            we,
  input  aau_pkg::state_t state_next,
  output aau_pkg::state_t state
);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (we) begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/aau_alu.sv
// Single-pass execute logic: one instruction against the current state.
// Depends on aau_pkg.
`timescale 1ns / 1ps

module aau_alu (
  input  aau_pkg::cmd_t   cmd,
  input  aau_pkg::state_t state,
  output aau_pkg::state_t state_next,
  output aau_pkg::res_t   result
);

  logic [15:0] hl;
  logic [7:0]  byteop;
  logic [7:0]  operand;
  logic        is_sub;
  logic        use_cy;
  logic        cin;
  logic [7:0]  b_in;
  logic        c_in;
  logic [8:0]  sum9;
  logic [4:0]  half;
  logic [7:0]  incdec;
  logic [1:0]  psel;
  logic [15:0] pair_val;
  logic [15:0] pair_new;
  logic [16:0] dad_sum;

  assign hl = {state.gregs[4], state.gregs[5]};

  always_comb begin
    if (cmd.reg_select == aau_pkg::SEL_M) begin
      byteop = cmd.mem_data;
    end else if (cmd.reg_select == aau_pkg::SEL_A) begin
      byteop = state.acc;
    end else begin
      byteop = state.gregs[cmd.reg_select];
    end
  end

  // 8-bit add path; subtraction as A + ~op + not-borrow
  always_comb begin
    is_sub  = (cmd.opcode == aau_pkg::OP_SUB) || (cmd.opcode == aau_pkg::OP_SBB) ||
              (cmd.opcode == aau_pkg::OP_SUI) || (cmd.opcode == aau_pkg::OP_SBI);
    use_cy  = (cmd.opcode == aau_pkg::OP_ADC) || (cmd.opcode == aau_pkg::OP_SBB) ||
              (cmd.opcode == aau_pkg::OP_ACI) || (cmd.opcode == aau_pkg::OP_SBI);
    operand = (cmd.opcode >= aau_pkg::OP_ADI) ? cmd.imm_value : byteop;
    cin     = use_cy & state.flags.cy;
    b_in    = is_sub ? ~operand : operand;
    c_in    = is_sub ? ~cin : cin;
    sum9    = {1'b0, state.acc} + {1'b0, b_in} + {8'd0, c_in};
    half    = {1'b0, state.acc[3:0]} + {1'b0, b_in[3:0]} + {4'd0, c_in};
    incdec  = (cmd.opcode == aau_pkg::OP_INR) ? byteop + 8'd1 : byteop - 8'd1;
  end

  // pair path
  always_comb begin
    psel     = cmd.reg_select[1:0];
    pair_val = (psel == aau_pkg::PAIR_SP) ? state.sp :
               {state.gregs[{psel, 1'b0}], state.gregs[{psel, 1'b1}]};
    pair_new = (cmd.opcode == aau_pkg::OP_INX) ? pair_val + 16'd1 : pair_val - 16'd1;
    dad_sum  = {1'b0, hl} + {1'b0, pair_val};
  end

  always_comb begin
    state_next         = state;
    result             = '0;
    result.hl_address  = hl;
    unique case (aau_pkg::op_t'(cmd.opcode))
      aau_pkg::OP_ADD, aau_pkg::OP_ADC, aau_pkg::OP_SUB, aau_pkg::OP_SBB,
      aau_pkg::OP_ADI, aau_pkg::OP_ACI, aau_pkg::OP_SUI, aau_pkg::OP_SBI: begin
        state_next.acc      = sum9[7:0];
        state_next.flags.s  = sum9[7];
        state_next.flags.z  = (sum9[7:0] == 8'd0);
        state_next.flags.p  = ~^sum9[7:0];
        state_next.flags.ac = half[4];
        state_next.flags.cy = is_sub ? ~sum9[8] : sum9[8];
      end
      aau_pkg::OP_INR, aau_pkg::OP_DCR: begin
        state_next.flags.s  = incdec[7];
        state_next.flags.z  = (incdec == 8'd0);
        state_next.flags.p  = ~^incdec;
        state_next.flags.ac = (cmd.opcode == aau_pkg::OP_INR) ? (incdec[3:0] == 4'h0) :
                                                                (incdec[3:0] != 4'hF);
        if (cmd.reg_select == aau_pkg::SEL_M) begin
          result.mem_write = 1'b1;
          result.mem_wdata = incdec;
        end else if (cmd.reg_select == aau_pkg::SEL_A) begin
          state_next.acc = incdec;
        end else begin
          state_next.gregs[cmd.reg_select] = incdec;
        end
      end
      aau_pkg::OP_INX, aau_pkg::OP_DCX: begin
        if (psel == aau_pkg::PAIR_SP) begin
          state_next.sp = pair_new;
        end else begin
          state_next.gregs[{psel, 1'b0}] = pair_new[15:8];
          state_next.gregs[{psel, 1'b1}] = pair_new[7:0];
        end
        result.pair_result = pair_new;
      end
      aau_pkg::OP_DAD: begin
        state_next.gregs[4] = dad_sum[15:8];
        state_next.gregs[5] = dad_sum[7:0];
        state_next.flags.cy = dad_sum[16];
        result.pair_result  = dad_sum[15:0];
      end
      default: begin
        // undefined opcodes: no change
      end
    endcase
    result.acc_out = state_next.acc;
    result.flags   = state_next.flags;
  end

endmodule

FILE: rtl/accumulator_alu_with_pair_ops_unit.sv
// Top level of the accumulator ALU with pair operations.
// Depends on aau_pkg, aau_if, aau_regs and aau_alu.
`timescale 1ns / 1ps

// Usage
// - cmd: one instruction word per handshake (opcode, reg_select, imm_value and
//   mem_data, the byte at HL for an M operand).
// - res: one result word per instruction: accumulator, flags, memory write
//   for INR M / DCR M, HL before the instruction and the new pair value.
// - An instruction word is caught in an input register; once the result slot
//   is free or draining, the execute logic runs against the architectural
//   registers, which update at the same edge that loads the result register
//   and raises res.valid (two register stages in all).
// - Throughput is one instruction per cycle while res.ready stays high: each
//   word is a single 8-bit or 16-bit add with flag logic, and the state it
//   writes is ready for the very next word.
// - If the receiver stalls, the result register holds its word, the input
//   register fills and cmd.ready drops; nothing is lost or repeated.
// - Synchronous reset clears A, B-L, SP, the flags and both valid bits.
module accumulator_alu_with_pair_ops_unit (
  input logic      clk,
  input logic      rst,
  aau_cmd_if.sink  cmd,
  aau_res_if.source res
);

  aau_pkg::cmd_t   cmd_q;
  logic            cmd_valid;
  aau_pkg::res_t   res_q;
  logic            res_valid;
  aau_pkg::state_t state;
  aau_pkg::state_t state_next;
  aau_pkg::res_t   alu_res;
  logic            exec;
  logic            cmd_take;

  // execute when an instruction waits and the result slot is free or draining
  assign exec      = cmd_valid && (!res_valid || res.ready);
  assign cmd.ready = !cmd_valid || exec;
  assign cmd_take  = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (cmd_take) begin
      cmd_valid <= 1'b1;
    end else if (exec) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cmd_q <= '{opcode: cmd.opcode, reg_select: cmd.reg_select,
                 imm_value: cmd.imm_value, mem_data: cmd.mem_data};
    end
  end

  aau_alu u_alu (
    .cmd        (cmd_q),
    .state      (state),
    .state_next (state_next),
    .result     (alu_res)
  );

  aau_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .we         (exec),
    .state_next (state_next),
    .state      (state)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (exec) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      res_q <= alu_res;
    end
  end

  assign res.valid          = res_valid;
  assign res.acc_out        = res_q.acc_out;
  assign res.sign_flag      = res_q.flags.s;
  assign res.zero_flag      = res_q.flags.z;
  assign res.aux_carry_flag = res_q.flags.ac;
  assign res.parity_flag    = res_q.flags.p;
  assign res.carry_flag_out = res_q.flags.cy;
  assign res.mem_write      = res_q.mem_write;
  assign res.mem_wdata      = res_q.mem_wdata;
  assign res.hl_address     = res_q.hl_address;
  assign res.pair_result    = res_q.pair_result;

  // a stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.ready |-> !exec)
    else $error("result overwritten while stalled");

  // every executed instruction shows a result next cycle
  a_exec_res: assert property (@(posedge clk) disable iff (rst)
    exec |=> res_valid)
    else $error("executed instruction produced no result");

  // register state moves only when an instruction executes
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !exec |=> $stable(state))
    else $error("state changed without an instruction");

  // INR M / DCR M write memory and flags, never the accumulator or B-L
  a_mem_only: assert property (@(posedge clk) disable iff (rst)
    exec && alu_res.mem_write |-> (state_next.acc == state.acc) &&
                                  (state_next.gregs == state.gregs))
    else $error("memory increment wrote a register");

  // an accepted word is held until it executes
  a_cmd_held: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !exec |=> cmd_valid && $stable(cmd_q))
    else $error("pending instruction lost");

endmodule

FILE: sim/tb.sv
// Self-checking bench for accumulator_alu_with_pair_ops_unit: table rows, then random words,
// each result checked against a hand-worked value or a cycle-free model of the register file.
// Depends on aau_pkg, aau_if and the unit's RTL.
`timescale 1ns / 1ps

module tb;

  // opcodes outside the instruction set; the unit treats them as no-ops
  localparam logic [3:0] OP_NOP_13 = 4'd13;
  localparam logic [3:0] OP_NOP_15 = 4'd15;

  localparam int N_RANDOM    = 1825;
  localparam int LONG_HOLD   = 120;   // receiver hold-off, in cycles
  localparam int HOLD_AT     = 400;   // result count that triggers it
  localparam int TAIL_CYCLES = 10;    // idle tail that catches stray words
  // slowest legal run stays well under this limit (1 in 4 ready, long gaps, one hold-off)
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic [3:0]    op;
    logic [2:0]    sel;
    logic [7:0]    imm;
    logic [7:0]    mem;
    logic          typed;   // want holds a hand-worked result
    aau_pkg::res_t want;
  } instr_row_t;

  localparam aau_pkg::res_t UNTYPED = '0;
  localparam int N_DIRECTED = 26;

  // want columns: acc, flags SZ-AC-P-CY, mem_write, mem_wdata, hl_address, pair_result
  localparam instr_row_t DIRECTED_TBL [N_DIRECTED] = '{
    '{aau_pkg::OP_ADI, 3'd0, 8'h00, 8'h00, 1'b1,
      {8'h00, 5'b01010, 1'b0, 8'h00, 16'h0000, 16'h0000}},
    '{aau_pkg::OP_ADI, 3'd0, 8'hFF, 8'h00, 1'b1,
      {8'hFF, 5'b10010, 1'b0, 8'h00, 16'h0000, 16'h0000}},
    '{aau_pkg::OP_ADI, 3'd0, 8'h01, 8'h00, 1'b1,
      {8'h00, 5'b01111, 1'b0, 8'h00, 16'h0000, 16'h0000}},
    '{aau_pkg::OP_ACI, 3'd0, 8'hFF, 8'h00, 1'b1,
      {8'h00, 5'b01111, 1'b0, 8'h00, 16'h0000, 16'h0000}},
    '{aau_pkg::OP_SUI, 3'd0, 8'h01, 8'h00, 1'b1,
      {8'hFF, 5'b10011, 1'b0, 8'h00, 16'h0000, 16'h0000}},
    '{aau_pkg::OP_SBI, 3'd0, 8'h00, 8'h00, 1'b1,
      {8'hFE, 5'b10100, 1'b0, 8'h00, 16'h0000, 16'h0000}},
    // INR/DCR on A: carry is left alone, AC follows the nibble rule
    '{aau_pkg::OP_INR, aau_pkg::SEL_A, 8'h00, 8'h00, 1'b1,
      {8'hFF, 5'b10010, 1'b0, 8'h00, 16'h0000, 16'h0000}},
    '{aau_pkg::OP_INR, aau_pkg::SEL_A, 8'h00, 8'h00, 1'b1,
      {8'h00, 5'b01110, 1'b0, 8'h00, 16'h0000, 16'h0000}},
    '{aau_pkg::OP_DCR, aau_pkg::SEL_A, 8'h00, 8'h00, 1'b1,
      {8'hFF, 5'b10010, 1'b0, 8'h00, 16'h0000, 16'h0000}},
    // memory operand: the new byte goes out on the write port only
    '{aau_pkg::OP_DCR, aau_pkg::SEL_M, 8'h00, 8'h00, 1'b1,
      {8'hFF, 5'b10010, 1'b1, 8'hFF, 16'h0000, 16'h0000}},
    '{aau_pkg::OP_INR, aau_pkg::SEL_M, 8'h00, 8'hFF, 1'b1,
      {8'hFF, 5'b01110, 1'b1, 8'h00, 16'h0000, 16'h0000}},
    // pair ops wrap at 16 bits; selector 7 and 6 fold onto SP and HL
    '{aau_pkg::OP_DCX, 3'd3, 8'h00, 8'h00, 1'b1,
      {8'hFF, 5'b01110, 1'b0, 8'h00, 16'h0000, 16'hFFFF}},
    '{aau_pkg::OP_INX, 3'd7, 8'h00, 8'h00, 1'b1,
      {8'hFF, 5'b01110, 1'b0, 8'h00, 16'h0000, 16'h0000}},
    '{aau_pkg::OP_DCX, 3'd2, 8'h00, 8'h00, 1'b1,
      {8'hFF, 5'b01110, 1'b0, 8'h00, 16'h0000, 16'hFFFF}},
    '{aau_pkg::OP_DAD, 3'd6, 8'h00, 8'h00, 1'b1,
      {8'hFF, 5'b01111, 1'b0, 8'h00, 16'hFFFF, 16'hFFFE}},
    '{aau_pkg::OP_ADD, 3'd4,           8'h00, 8'h00, 1'b0, UNTYPED},
    '{aau_pkg::OP_ADC, 3'd5,           8'h00, 8'h00, 1'b0, UNTYPED},
    '{aau_pkg::OP_SUB, aau_pkg::SEL_M, 8'h00, 8'h80, 1'b0, UNTYPED},
    '{aau_pkg::OP_SBB, aau_pkg::SEL_A, 8'h00, 8'h00, 1'b0, UNTYPED},
    '{aau_pkg::OP_ADD, aau_pkg::SEL_M, 8'h00, 8'h7F, 1'b0, UNTYPED},
    '{aau_pkg::OP_INX, 3'd0,           8'h00, 8'h00, 1'b0, UNTYPED},
    '{aau_pkg::OP_DCX, 3'd5,           8'h00, 8'h00, 1'b0, UNTYPED},
    '{aau_pkg::OP_DAD, 3'd3,           8'h00, 8'h00, 1'b0, UNTYPED},
    '{aau_pkg::OP_INR, 3'd0,           8'h00, 8'h00, 1'b0, UNTYPED},
    '{OP_NOP_13, 3'd3, 8'hA5, 8'h5A, 1'b0, UNTYPED},
    '{OP_NOP_15, 3'd7, 8'hFF, 8'hFF, 1'b0, UNTYPED}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  aau_cmd_if cmd_if ();
  aau_res_if res_if ();

  accumulator_alu_with_pair_ops_unit u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if)
  );

  // ---------------------------------------------------------------------------
  // Architectural state as the bench sees it; matches the unit's reset values.
  // ---------------------------------------------------------------------------
  logic [7:0]      arch_acc = '0;
  logic [7:0]      arch_gregs [aau_pkg::NUM_GREGS] = '{default: '0};  // B, C, D, E, H, L
  logic [15:0]     arch_sp = '0;
  aau_pkg::flags_t arch_flags = '0;

  aau_pkg::res_t pending_results [$];
  int   n_mismatches = 0;
  int   n_results = 0;
  int   n_cycles = 0;

  function automatic aau_pkg::flags_t szp_flags(input logic [7:0] v);
    aau_pkg::flags_t f;
    f   = '0;
    f.s = v[7];
    f.z = (v == 8'h00);
    f.p = ~^v;
    return f;
  endfunction

  function automatic logic [15:0] read_pair(input logic [1:0] pair);
    if (pair == aau_pkg::PAIR_SP) return arch_sp;
    return {arch_gregs[{pair, 1'b0}], arch_gregs[{pair, 1'b1}]};
  endfunction

  function automatic void write_pair(input logic [1:0] pair, input logic [15:0] v);
    if (pair == aau_pkg::PAIR_SP) begin
      arch_sp = v;
    end else begin
      arch_gregs[{pair, 1'b0}] = v[15:8];
      arch_gregs[{pair, 1'b1}] = v[7:0];
    end
  endfunction

  // Subtract runs as A + ~op + !borrow; CY is the inverted carry out there.
  function automatic void add_to_acc(input logic [7:0] operand, input logic subtract,
                                     input logic with_carry);
    logic       cin;
    logic [7:0] addend;
    logic       c;
    logic [8:0] sum;
    logic [4:0] half;
    cin    = with_carry & arch_flags.cy;
    addend = subtract ? ~operand : operand;
    c      = subtract ? ~cin : cin;
    sum    = {1'b0, arch_acc} + {1'b0, addend} + {8'b0, c};
    half   = {1'b0, arch_acc[3:0]} + {1'b0, addend[3:0]} + {4'b0, c};
    arch_acc      = sum[7:0];
    arch_flags    = szp_flags(sum[7:0]);
    arch_flags.ac = half[4];
    arch_flags.cy = subtract ? ~sum[8] : sum[8];
  endfunction

  // Runs one instruction against the bench's state and returns its result word.
  function automatic aau_pkg::res_t execute_instr(input logic [3:0] op, input logic [2:0] sel,
                                                  input logic [7:0] imm, input logic [7:0] mem);
    aau_pkg::res_t r;
    logic [7:0]    operand;
    logic [7:0]    stepped;
    logic [15:0]   hl_before;
    logic [15:0]   pair_val;
    logic [16:0]   dad_sum;
    logic          keep_cy;
    r           = '0;
    hl_before   = read_pair(aau_pkg::PAIR_HL);
    r.hl_address = hl_before;
    if (sel == aau_pkg::SEL_M) operand = mem;
    else if (sel == aau_pkg::SEL_A) operand = arch_acc;
    else operand = arch_gregs[sel];
    case (op)
      aau_pkg::OP_ADD: add_to_acc(operand, 1'b0, 1'b0);
      aau_pkg::OP_ADC: add_to_acc(operand, 1'b0, 1'b1);
      aau_pkg::OP_SUB: add_to_acc(operand, 1'b1, 1'b0);
      aau_pkg::OP_SBB: add_to_acc(operand, 1'b1, 1'b1);
      aau_pkg::OP_ADI: add_to_acc(imm, 1'b0, 1'b0);
      aau_pkg::OP_ACI: add_to_acc(imm, 1'b0, 1'b1);
      aau_pkg::OP_SUI: add_to_acc(imm, 1'b1, 1'b0);
      aau_pkg::OP_SBI: add_to_acc(imm, 1'b1, 1'b1);
      aau_pkg::OP_INR, aau_pkg::OP_DCR: begin
        stepped = (op == aau_pkg::OP_INR) ? operand + 8'd1 : operand - 8'd1;
        keep_cy = arch_flags.cy;
        arch_flags    = szp_flags(stepped);
        arch_flags.cy = keep_cy;
        arch_flags.ac = (op == aau_pkg::OP_INR) ? (stepped[3:0] == 4'h0) :
                                                  (stepped[3:0] != 4'hF);
        if (sel == aau_pkg::SEL_M) begin
          r.mem_write = 1'b1;
          r.mem_wdata = stepped;
        end else if (sel == aau_pkg::SEL_A) begin
          arch_acc = stepped;
        end else begin
          arch_gregs[sel] = stepped;
        end
      end
      aau_pkg::OP_INX, aau_pkg::OP_DCX: begin
        pair_val = read_pair(sel[1:0]);
        pair_val = (op == aau_pkg::OP_INX) ? pair_val + 16'd1 : pair_val - 16'd1;
        write_pair(sel[1:0], pair_val);
        r.pair_result = pair_val;
      end
      aau_pkg::OP_DAD: begin
        dad_sum = {1'b0, hl_before} + {1'b0, read_pair(sel[1:0])};
        write_pair(aau_pkg::PAIR_HL, dad_sum[15:0]);
        arch_flags.cy = dad_sum[16];
        r.pair_result = dad_sum[15:0];
      end
      default: ;  // no-op opcodes: state untouched
    endcase
    r.acc_out = arch_acc;
    r.flags   = arch_flags;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offers one instruction word and returns at the edge that takes it.
  task automatic offer(input logic [3:0] op, input logic [2:0] sel, input logic [7:0] imm,
                       input logic [7:0] mem, input logic typed, input aau_pkg::res_t want);
    aau_pkg::res_t predicted;
    cmd_if.valid      <= 1'b1;
    cmd_if.opcode     <= op;
    cmd_if.reg_select <= sel;
    cmd_if.imm_value  <= imm;
    cmd_if.mem_data   <= mem;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    predicted = execute_instr(op, sel, imm, mem);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Waits on the clock before it first checks the queue, so valid is never lowered and raised in one step.
  task automatic pause_until_drained();
    cmd_if.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Bytes lean on the carry and nibble boundaries now and then.
  function automatic logic [7:0] pick_byte();
    logic [7:0] corners [6] = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h0F, 8'hF0};
    if ($urandom_range(0, 7) == 0) return corners[$urandom_range(0, 5)];
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin : sender
    int         sent;
    int         burst;
    int         gap;
    bit         mid_pause_done;
    logic [3:0] op;
    logic [2:0] sel;
    sent           = 0;
    mid_pause_done = 1'b0;
    cmd_if.valid      <= 1'b0;
    cmd_if.opcode     <= '0;
    cmd_if.reg_select <= '0;
    cmd_if.imm_value  <= '0;
    cmd_if.mem_data   <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed table, short random gaps between words
    for (int i = 0; i < N_DIRECTED; i++) begin
      offer(DIRECTED_TBL[i].op, DIRECTED_TBL[i].sel, DIRECTED_TBL[i].imm,
            DIRECTED_TBL[i].mem, DIRECTED_TBL[i].typed, DIRECTED_TBL[i].want);
      gap = $urandom_range(0, 2);
      if (gap > 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    pause_until_drained();

    // random bursts; one full drain halfway through
    while (sent < N_RANDOM) begin
      burst = $urandom_range(1, 32);
      for (int k = 0; k < burst && sent < N_RANDOM; k++) begin
        op  = 4'($urandom_range(aau_pkg::OP_ADD, aau_pkg::OP_DAD));
        sel = 3'($urandom_range(0, 7));
        offer(op, sel, pick_byte(), pick_byte(), 1'b0, UNTYPED);
        sent++;
      end
      if (!mid_pause_done && sent >= N_RANDOM / 2) begin
        mid_pause_done = 1'b1;
        pause_until_drained();
      end else if ($urandom_range(0, 2) != 0) begin
        gap = ($urandom_range(0, 15) == 0) ? 30 : $urandom_range(1, 8);
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end

    cmd_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver side: stall patterns in spans, plus one long hold-off
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int         mode;
    int         span;
    bit         hold_done;
    logic [7:0] mask;
    hold_done = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 4);
      span = $urandom_range(10, 80);
      mask = 8'($urandom_range(1, 255));
      repeat (span) begin
        @(posedge clk);
        if (!hold_done && n_results >= HOLD_AT) begin
          // sender keeps offering meanwhile, so the unit backs up and drops cmd.ready
          hold_done = 1'b1;
          res_if.ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
        end
        case (mode)
          0, 1:    res_if.ready <= 1'b1;
          2:       res_if.ready <= 1'($urandom_range(0, 1));
          3:       res_if.ready <= ($urandom_range(0, 3) == 0);
          default: begin
            res_if.ready <= mask[0];
            mask = {mask[0], mask[7:1]};
          end
        endcase
      end
    end
  end

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      n_mismatches++;
    end
  endtask

  always @(posedge clk) begin
    aau_pkg::res_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result word with no instruction outstanding");
        n_mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("acc_out", 16'(want.acc_out), 16'(res_if.acc_out));
        check_field("sign_flag", 16'(want.flags.s), 16'(res_if.sign_flag));
        check_field("zero_flag", 16'(want.flags.z), 16'(res_if.zero_flag));
        check_field("aux_carry_flag", 16'(want.flags.ac), 16'(res_if.aux_carry_flag));
        check_field("parity_flag", 16'(want.flags.p), 16'(res_if.parity_flag));
        check_field("carry_flag_out", 16'(want.flags.cy), 16'(res_if.carry_flag_out));
        check_field("mem_write", 16'(want.mem_write), 16'(res_if.mem_write));
        check_field("mem_wdata", 16'(want.mem_wdata), 16'(res_if.mem_wdata));
        check_field("hl_address", want.hl_address, res_if.hl_address);
        check_field("pair_result", want.pair_result, res_if.pair_result);
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

FILE: files.f
rtl/aau_pkg.sv
rtl/aau_if.sv
rtl/aau_regs.sv
rtl/aau_alu.sv
rtl/accumulator_alu_with_pair_ops_unit.sv
sim/tb.sv
